@@ src/assert_macros.svh @@
// assertion macros shared by the polyline smoothing rtl
// every macro samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PWS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pws_pkg.sv @@
// types and constants of the polyline smoothing block
// used by pws_ctrl, pws_dp and the top level; no dependencies
package pws_pkg;

	localparam int COORD_W = 32;
	localparam int GAIN_W  = 16;
	localparam int PASS_W  = 8;
	localparam int CFG_W   = 16;

	localparam logic [PASS_W-1:0] PASS_COUNT_RST = 8'd10;
	localparam logic [GAIN_W-1:0] STEP_GAIN_RST  = 16'd131;

	typedef enum logic {
		REG_PASS_COUNT = 1'b0,
		REG_STEP_GAIN  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_STORE,
		OP_SHIFT,
		OP_ACC_CLR,
		OP_SQUARE,
		OP_ACC_ADD,
		OP_ROOT_GO,
		OP_WGT_LOAD,
		OP_WGT_HALVE,
		OP_MUL_PREV,
		OP_NUM_PREV,
		OP_MUL_NEXT,
		OP_NUM_NEXT,
		OP_DIV_GO,
		OP_GAIN,
		OP_APPLY,
		OP_WRITE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t   op;
		axis_t axis;
	} cmd_t;

	typedef struct packed {
		logic root_busy;
		logic root_done;
		logic div_busy;
		logic div_done;
		logic zero_w;
		logic big_w;
	} sts_t;

endpackage

@@ src/pws_isqrt.sv @@
// bit-pair integer square root, floor of sqrt of a 64-bit value
// one result bit per cycle; no package dependencies
module pws_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;
	logic        ge;

	assign trial = res_q + bit_q;
	assign ge    = (v_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[31:0];

endmodule

@@ src/pws_div.sv @@
// restoring unsigned divider, 64-bit dividend by a divisor below 2^31
// one quotient bit per cycle; no package dependencies
module pws_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[63]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/pws_dp.sv @@
// datapath: point memory, neighbor window, distance and weighted move arithmetic
// depends on pws_pkg, pws_isqrt and pws_div
module pws_dp #(
	parameter int MAX_POINTS = 64,
	parameter int AW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pws_pkg::cmd_t         cmd,
	input  logic [AW-1:0]         addr,
	input  logic signed [31:0]    px,
	input  logic signed [31:0]    py,
	input  logic signed [31:0]    pz,
	input  logic [15:0]           step_gain,
	output logic signed [31:0]    qx,
	output logic signed [31:0]    qy,
	output logic signed [31:0]    qz,
	output pws_pkg::sts_t         sts
);

	pws_pkg::point_t mem_q [MAX_POINTS];
	pws_pkg::point_t rd_q;
	pws_pkg::point_t prev_q;
	pws_pkg::point_t cur_q;
	pws_pkg::point_t next_q;
	pws_pkg::point_t new_q;
	pws_pkg::point_t out_q;
	pws_pkg::point_t in_pt;

	logic [63:0]        acc_q;
	logic [63:0]        prod_q;
	logic [31:0]        e1_q;
	logic [31:0]        e2_q;
	logic [31:0]        w1_q;
	logic [31:0]        w2_q;
	logic signed [64:0] num_q;
	logic               term_neg_q;
	logic               avg_neg_q;

	logic signed [31:0] pa;
	logic signed [31:0] ca;
	logic signed [31:0] na;
	logic signed [32:0] dprev;
	logic signed [32:0] dnext;
	logic signed [32:0] dprev_neg;
	logic signed [32:0] dnext_neg;
	logic [31:0]        mag_p;
	logic [31:0]        mag_n;
	logic [63:0]        sq_w;
	logic [63:0]        mul_p;
	logic [63:0]        mul_n;
	logic [63:0]        gain_w;
	logic [64:0]        acc_sum;
	logic [32:0]        wsum;
	logic signed [64:0] term;
	logic signed [64:0] num_neg;
	logic [63:0]        num_mag;
	logic signed [34:0] mv;
	logic signed [34:0] moved;
	logic signed [31:0] moved_sat;

	logic        root_busy;
	logic        root_done;
	logic [31:0] root;
	logic        div_busy;
	logic        div_done;
	logic [63:0] quotient;

	function automatic logic signed [31:0] pick(input pws_pkg::point_t p,
			input pws_pkg::axis_t a);
		logic signed [31:0] r;
		case (a)
			pws_pkg::AXIS_X: r = p.x;
			pws_pkg::AXIS_Y: r = p.y;
			pws_pkg::AXIS_Z: r = p.z;
			default:         r = p.x;
		endcase
		return r;
	endfunction

	assign in_pt = '{x: px, y: py, z: pz};

	assign pa = pick(prev_q, cmd.axis);
	assign ca = pick(cur_q, cmd.axis);
	assign na = pick(next_q, cmd.axis);

	assign dprev     = 33'(pa) - 33'(ca);
	assign dnext     = 33'(na) - 33'(ca);
	assign dprev_neg = -dprev;
	assign dnext_neg = -dnext;
	assign mag_p     = dprev[32] ? dprev_neg[31:0] : dprev[31:0];
	assign mag_n     = dnext[32] ? dnext_neg[31:0] : dnext[31:0];

	assign sq_w   = mag_n * mag_n;
	assign mul_p  = w1_q * mag_p;
	assign mul_n  = w2_q * mag_n;
	assign gain_w = quotient[32:0] * step_gain;

	// squared length saturates at all ones
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
	assign wsum    = {1'b0, w1_q} + {1'b0, w2_q};

	assign term    = term_neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
	assign num_neg = -num_q;
	assign num_mag = num_q[64] ? num_neg[63:0] : num_q[63:0];

	// move magnitude is (|avg| * gain) >> 16, sign of the numerator
	assign mv    = avg_neg_q ? -$signed({2'b00, prod_q[48:16]}) : $signed({2'b00, prod_q[48:16]});
	assign moved = 35'(ca) + mv;
	always_comb begin
		if (moved > 35'sd2147483647)
			moved_sat = 32'sh7fff_ffff;
		else if (moved < -35'sd2147483648)
			moved_sat = 32'sh8000_0000;
		else
			moved_sat = moved[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == pws_pkg::OP_STORE)
			mem_q[addr] <= in_pt;
		else if (cmd.op == pws_pkg::OP_WRITE)
			mem_q[addr] <= new_q;
		rd_q <= mem_q[addr];
	end

	always_ff @(posedge clk) begin
		if (root_done)
			e2_q <= root;
		case (cmd.op)
			pws_pkg::OP_SHIFT: begin
				prev_q <= cur_q;
				cur_q  <= next_q;
				next_q <= rd_q;
				e1_q   <= e2_q;
			end
			pws_pkg::OP_ACC_CLR:  acc_q <= '0;
			pws_pkg::OP_SQUARE:   prod_q <= sq_w;
			pws_pkg::OP_ACC_ADD:  acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
			pws_pkg::OP_WGT_LOAD: begin
				w1_q <= e1_q;
				w2_q <= e2_q;
			end
			pws_pkg::OP_WGT_HALVE: begin
				w1_q <= w1_q >> 1;
				w2_q <= w2_q >> 1;
			end
			pws_pkg::OP_MUL_PREV: begin
				prod_q     <= mul_p;
				term_neg_q <= dprev[32];
			end
			pws_pkg::OP_NUM_PREV: num_q <= term;
			pws_pkg::OP_MUL_NEXT: begin
				prod_q     <= mul_n;
				term_neg_q <= dnext[32];
			end
			pws_pkg::OP_NUM_NEXT: num_q <= num_q + term;
			pws_pkg::OP_DIV_GO:   avg_neg_q <= num_q[64];
			pws_pkg::OP_GAIN:     prod_q <= gain_w;
			pws_pkg::OP_APPLY: begin
				case (cmd.axis)
					pws_pkg::AXIS_X: new_q.x <= moved_sat;
					pws_pkg::AXIS_Y: new_q.y <= moved_sat;
					pws_pkg::AXIS_Z: new_q.z <= moved_sat;
					default:         new_q.x <= moved_sat;
				endcase
			end
			pws_pkg::OP_EMIT:     out_q <= rd_q;
			default: ;
		endcase
	end

	pws_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == pws_pkg::OP_ROOT_GO),
		.radicand (acc_q),
		.busy     (root_busy),
		.done     (root_done),
		.root     (root)
	);

	pws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == pws_pkg::OP_DIV_GO),
		.dividend (num_mag),
		.divisor  (wsum[31:0]),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign sts.root_busy = root_busy;
	assign sts.root_done = root_done;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.zero_w    = (e1_q == '0) && (e2_q == '0);
	assign sts.big_w     = (wsum[32:31] != 2'b00);

	assign qx = out_q.x;
	assign qy = out_q.y;
	assign qz = out_q.z;

endmodule

@@ src/pws_ctrl.sv @@
// controller: stroke loading, pass and point sequencing, result emission
// depends on pws_pkg; drives pws_dp through cmd_t and reads sts_t
module pws_ctrl #(
	parameter int MAX_POINTS = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               last_out,
	output logic               overflowed,
	input  logic [7:0]         pass_count,
	input  pws_pkg::sts_t      sts,
	output pws_pkg::cmd_t      cmd,
	output logic [AW-1:0]      addr
);

	typedef enum logic [4:0] {
		S_LOAD,
		S_PRIME_RD,
		S_PRIME_SH0,
		S_PRIME_SH1,
		S_LINE_RD,
		S_LINE_SH,
		S_DIST_CLR,
		S_DIST_SQ,
		S_DIST_ACC,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_WGT_LOAD,
		S_WGT_CHK,
		S_MUL1,
		S_NUM1,
		S_MUL2,
		S_NUM2,
		S_DIV_GO,
		S_DIV_WAIT,
		S_GAIN,
		S_APPLY,
		S_WRITE,
		S_STEP,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic [AW-1:0]  idx_q;
	logic [7:0]     pass_q;
	pws_pkg::axis_t axis_q;
	logic           prime_q;
	logic           out_valid_q;
	logic           last_out_q;
	logic           overflowed_q;

	logic          in_xfer;
	logic          out_xfer;
	logic          out_free;
	logic          full;
	logic [CW-1:0] count_next;
	logic [CW-1:0] count_m1;
	logic [CW-1:0] count_m2;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] last_inner;
	logic [AW-1:0] idx_p1;

	assign in_stall   = (state_q != S_LOAD);
	assign in_xfer    = in_valid && !in_stall;
	assign out_xfer   = out_valid_q && !out_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign full       = (count_q == CW'(MAX_POINTS));
	assign count_next = full ? count_q : count_q + CW'(1);
	assign count_m1   = count_q - CW'(1);
	assign count_m2   = count_q - CW'(2);
	assign last_idx   = count_m1[AW-1:0];
	assign last_inner = count_m2[AW-1:0];
	assign idx_p1     = idx_q + AW'(1);

	always_comb begin
		cmd.op   = pws_pkg::OP_NONE;
		cmd.axis = axis_q;
		addr     = idx_q;
		unique case (state_q)
			S_LOAD: begin
				addr = count_q[AW-1:0];
				if (in_xfer && !full)
					cmd.op = pws_pkg::OP_STORE;
			end
			S_PRIME_RD:  addr = '0;
			S_PRIME_SH0: begin
				cmd.op = pws_pkg::OP_SHIFT;
				addr   = AW'(1);
			end
			S_PRIME_SH1: cmd.op = pws_pkg::OP_SHIFT;
			S_LINE_RD:   addr = idx_p1;
			S_LINE_SH:   cmd.op = pws_pkg::OP_SHIFT;
			S_DIST_CLR:  cmd.op = pws_pkg::OP_ACC_CLR;
			S_DIST_SQ:   cmd.op = pws_pkg::OP_SQUARE;
			S_DIST_ACC:  cmd.op = pws_pkg::OP_ACC_ADD;
			S_ROOT_GO:   cmd.op = pws_pkg::OP_ROOT_GO;
			S_ROOT_WAIT: ;
			S_WGT_LOAD:  cmd.op = pws_pkg::OP_WGT_LOAD;
			S_WGT_CHK: begin
				if (!sts.zero_w && sts.big_w)
					cmd.op = pws_pkg::OP_WGT_HALVE;
			end
			S_MUL1:      cmd.op = pws_pkg::OP_MUL_PREV;
			S_NUM1:      cmd.op = pws_pkg::OP_NUM_PREV;
			S_MUL2:      cmd.op = pws_pkg::OP_MUL_NEXT;
			S_NUM2:      cmd.op = pws_pkg::OP_NUM_NEXT;
			S_DIV_GO:    cmd.op = pws_pkg::OP_DIV_GO;
			S_DIV_WAIT:  ;
			S_GAIN:      cmd.op = pws_pkg::OP_GAIN;
			S_APPLY:     cmd.op = pws_pkg::OP_APPLY;
			S_WRITE:     cmd.op = pws_pkg::OP_WRITE;
			S_STEP:      ;
			S_EMIT_RD:   ;
			S_EMIT_LD: begin
				if (out_free)
					cmd.op = pws_pkg::OP_EMIT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			pass_q       <= '0;
			axis_q       <= pws_pkg::AXIS_X;
			prime_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			last_out_q   <= 1'b0;
			overflowed_q <= 1'b0;
		end else begin
			// a transfer frees the register unless the next point loads now
			if (out_xfer && cmd.op != pws_pkg::OP_EMIT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (full)
							ovf_q <= 1'b1;
						else
							count_q <= count_q + CW'(1);
						if (last_in) begin
							pass_q <= '0;
							idx_q  <= '0;
							if (count_next >= CW'(3) && pass_count != 8'd0)
								state_q <= S_PRIME_RD;
							else
								state_q <= S_EMIT_RD;
						end
					end
				end
				S_PRIME_RD:  state_q <= S_PRIME_SH0;
				S_PRIME_SH0: state_q <= S_PRIME_SH1;
				S_PRIME_SH1: begin
					prime_q <= 1'b1;
					idx_q   <= AW'(1);
					state_q <= S_DIST_CLR;
				end
				S_LINE_RD:   state_q <= S_LINE_SH;
				S_LINE_SH:   state_q <= S_DIST_CLR;
				S_DIST_CLR: begin
					axis_q  <= pws_pkg::AXIS_X;
					state_q <= S_DIST_SQ;
				end
				S_DIST_SQ:   state_q <= S_DIST_ACC;
				S_DIST_ACC: begin
					unique case (axis_q)
						pws_pkg::AXIS_X: begin
							axis_q  <= pws_pkg::AXIS_Y;
							state_q <= S_DIST_SQ;
						end
						pws_pkg::AXIS_Y: begin
							axis_q  <= pws_pkg::AXIS_Z;
							state_q <= S_DIST_SQ;
						end
						default:         state_q <= S_ROOT_GO;
					endcase
				end
				S_ROOT_GO:   state_q <= S_ROOT_WAIT;
				S_ROOT_WAIT: begin
					if (sts.root_done) begin
						// priming only yields the first edge length
						prime_q <= 1'b0;
						state_q <= prime_q ? S_LINE_RD : S_WGT_LOAD;
					end
				end
				S_WGT_LOAD:  state_q <= S_WGT_CHK;
				S_WGT_CHK: begin
					if (sts.zero_w) begin
						state_q <= S_STEP;
					end else if (!sts.big_w) begin
						axis_q  <= pws_pkg::AXIS_X;
						state_q <= S_MUL1;
					end
				end
				S_MUL1:      state_q <= S_NUM1;
				S_NUM1:      state_q <= S_MUL2;
				S_MUL2:      state_q <= S_NUM2;
				S_NUM2:      state_q <= S_DIV_GO;
				S_DIV_GO:    state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (sts.div_done)
						state_q <= S_GAIN;
				end
				S_GAIN:      state_q <= S_APPLY;
				S_APPLY: begin
					unique case (axis_q)
						pws_pkg::AXIS_X: begin
							axis_q  <= pws_pkg::AXIS_Y;
							state_q <= S_MUL1;
						end
						pws_pkg::AXIS_Y: begin
							axis_q  <= pws_pkg::AXIS_Z;
							state_q <= S_MUL1;
						end
						default:         state_q <= S_WRITE;
					endcase
				end
				S_WRITE:     state_q <= S_STEP;
				S_STEP: begin
					if (idx_q == last_inner) begin
						if (pass_q == 8'(pass_count - 8'd1)) begin
							pass_q  <= '0;
							idx_q   <= '0;
							state_q <= S_EMIT_RD;
						end else begin
							pass_q  <= pass_q + 8'd1;
							state_q <= S_PRIME_RD;
						end
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_LINE_RD;
					end
				end
				S_EMIT_RD:   state_q <= S_EMIT_LD;
				S_EMIT_LD: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						last_out_q   <= (idx_q == last_idx);
						overflowed_q <= ovf_q;
						if (idx_q == last_idx) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							idx_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_p1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default:     state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign last_out   = last_out_q;
	assign overflowed = overflowed_q;

endmodule

@@ src/polyline_weighted_smoothing.sv @@
// top level of the length-weighted polyline smoothing block
// depends on pws_pkg, pws_ctrl, pws_dp and assert_macros.svh

// Points load at one per cycle into a single-port point memory until one marked
// last_in arrives; the input then stalls. For strokes of three or more points,
// pass_count Jacobi passes run, each walking the interior points in order with
// a three-point window. For each interior point in each pass, the bit-pair
// square root gives the edge length and, per coordinate, the shared restoring
// divider plus a handful of multiply steps give the move. After the last pass
// the points stream out through an output register, each read and then loaded;
// a load waits while the register holds a point that the sink stalls.
// Configuration writes (index 0 pass_count, index 1 step_gain) are always
// ready and belong between strokes.
module polyline_weighted_smoothing #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] qx,
	output logic signed [31:0] qy,
	output logic signed [31:0] qz,
	output logic               last_out,
	output logic               overflowed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [7:0]    pass_count_q;
	logic [15:0]   step_gain_q;
	pws_pkg::cmd_t cmd;
	pws_pkg::sts_t sts;
	logic [AW-1:0] addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= pws_pkg::PASS_COUNT_RST;
			step_gain_q  <= pws_pkg::STEP_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pws_pkg::reg_idx_t'(cfg_index))
				pws_pkg::REG_PASS_COUNT: pass_count_q <= cfg_data[7:0];
				pws_pkg::REG_STEP_GAIN:  step_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	pws_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.last_in    (last_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.last_out   (last_out),
		.overflowed (overflowed),
		.pass_count (pass_count_q),
		.sts        (sts),
		.cmd        (cmd),
		.addr       (addr)
	);

	pws_dp #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.step_gain (step_gain_q),
		.qx        (qx),
		.qy        (qy),
		.qz        (qz),
		.sts       (sts)
	);

	`PWS_ASSERT_IMPLY(a_root_go_idle, cmd.op == pws_pkg::OP_ROOT_GO,
		!sts.root_busy && !sts.div_busy, "root started while an iterative unit is busy")
	`PWS_ASSERT_NEXT(a_root_go_busy, cmd.op == pws_pkg::OP_ROOT_GO, sts.root_busy,
		"square root unit did not start")
	`PWS_ASSERT_IMPLY(a_div_operand, cmd.op == pws_pkg::OP_DIV_GO,
		!sts.zero_w && !sts.big_w, "divider started with a zero or wide weight sum")
	`PWS_ASSERT_IMPLY(a_load_idle, in_valid && !in_stall,
		!sts.root_busy && !sts.div_busy, "point transfer while smoothing is running")

endmodule

@@ bench/polyline_weighted_smoothing_tb.sv @@
// self-checking bench for polyline_weighted_smoothing: loads strokes, predicts the
// smoothed points in-bench and checks every emitted point; depends on pws_pkg and the rtl
`timescale 1ns / 100ps

module polyline_weighted_smoothing_tb;

	localparam int STROKE_CAP = 64;
	localparam int IDLE_LIMIT = 250000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic last;
	} stroke_point_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic last;
		logic ovf;
	} smoothed_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] px = '0, py = '0, pz = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] qx, qy, qz;
	logic last_out, overflowed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = pws_pkg::REG_PASS_COUNT;
	logic [15:0] cfg_data = '0;

	polyline_weighted_smoothing i_dut (.*);

	stroke_point_t pending_points[$];
	smoothed_point_t smoothed_expect[$];
	int errors = 0;
	int src_idle_pct = 11;
	int snk_stall_pct = 78;

	// predictor state
	logic signed [31:0] sx[STROKE_CAP], sy[STROKE_CAP], sz[STROKE_CAP];
	int stored_points = 0;
	logic dropped_points = 1'b0;
	logic [7:0] passes = pws_pkg::PASS_COUNT_RST;
	logic [15:0] gain = pws_pkg::STEP_GAIN_RST;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned diff_sq(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		longint unsigned m;
		d = longint'(a) - longint'(b);
		m = (d < 0) ? longint'(-d) : d;
		return m * m;
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned edge_len(logic signed [31:0] ax[STROKE_CAP],
			logic signed [31:0] ay[STROKE_CAP], logic signed [31:0] az[STROKE_CAP], int i, int j);
		longint unsigned s;
		s = diff_sq(ax[i], ax[j]);
		s = sat_sum(s, diff_sq(ay[i], ay[j]));
		s = sat_sum(s, diff_sq(az[i], az[j]));
		return int_sqrt(s);
	endfunction

	function automatic logic signed [31:0] shift_coord(logic signed [31:0] p,
			logic signed [31:0] c, logic signed [31:0] n, longint w1, longint w2);
		longint avg, mv, r;
		longint unsigned mag;
		avg = (w1 * (longint'(p) - longint'(c)) + w2 * (longint'(n) - longint'(c)))
			/ (w1 + w2);
		mag = (avg < 0) ? longint'(-avg) : avg;
		mag = (mag * longint'(gain)) >> 16;
		mv = (avg < 0) ? -longint'(mag) : longint'(mag);
		r = longint'(c) + mv;
		if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
		if (r < -64'sh8000_0000) r = -64'sh8000_0000;
		return r[31:0];
	endfunction

	task automatic smooth_stroke(int n);
		logic signed [31:0] ox[STROKE_CAP], oy[STROKE_CAP], oz[STROKE_CAP];
		longint unsigned e1, e2;
		if (n < 3) return;
		for (int p = 0; p < passes; p++) begin
			ox = sx;
			oy = sy;
			oz = sz;
			for (int i = 1; i < n - 1; i++) begin
				e1 = edge_len(ox, oy, oz, i, i - 1);
				e2 = edge_len(ox, oy, oz, i, i + 1);
				if (e1 + e2 == 0) continue;
				while (e1 + e2 >= (64'd1 << 31)) begin
					e1 = e1 >> 1;
					e2 = e2 >> 1;
				end
				sx[i] = shift_coord(ox[i-1], ox[i], ox[i+1], e1, e2);
				sy[i] = shift_coord(oy[i-1], oy[i], oy[i+1], e1, e2);
				sz[i] = shift_coord(oz[i-1], oz[i], oz[i+1], e1, e2);
			end
		end
	endtask

	task automatic predict_point(stroke_point_t pt);
		smoothed_point_t res;
		if (stored_points < STROKE_CAP) begin
			sx[stored_points] = pt.x;
			sy[stored_points] = pt.y;
			sz[stored_points] = pt.z;
			stored_points++;
		end else begin
			dropped_points = 1'b1;
		end
		if (!pt.last) return;
		smooth_stroke(stored_points);
		for (int k = 0; k < stored_points; k++) begin
			res.x = sx[k];
			res.y = sy[k];
			res.z = sz[k];
			res.last = (k == stored_points - 1);
			res.ovf = dropped_points;
			smoothed_expect.insert(smoothed_expect.size(), res);
		end
		stored_points = 0;
		dropped_points = 1'b0;
	endtask

	// driver
	always @(posedge clk) begin
		stroke_point_t pt;
		logic took;
		if (arst_n) begin
			took = in_valid && !in_stall;
			if (took) begin
				pt.x = px;
				pt.y = py;
				pt.z = pz;
				pt.last = last_in;
				predict_point(pt);
			end
			if (!in_valid || took) begin
				if (pending_points.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					pt = pending_points.pop_front();
					in_valid <= 1'b1;
					px <= pt.x;
					py <= pt.y;
					pz <= pt.z;
					last_in <= pt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		smoothed_point_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (smoothed_expect.size() == 0) begin
					$display("%0t: unexpected point x=%h y=%h z=%h", $time, qx, qy, qz);
					errors++;
				end else begin
					want = smoothed_expect.pop_front();
					if (qx !== want.x || qy !== want.y || qz !== want.z
							|| last_out !== want.last || overflowed !== want.ovf) begin
						$display("%0t: expected x=%h y=%h z=%h last=%b ovf=%b", $time,
							want.x, want.y, want.z, want.last, want.ovf);
						$display("%0t: actual   x=%h y=%h z=%h last=%b ovf=%b", $time,
							qx, qy, qz, last_out, overflowed);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired at %0t", $time);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_points.size() > 0 || in_valid || smoothed_expect.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(pws_pkg::reg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == pws_pkg::REG_PASS_COUNT) passes = val[7:0];
		else gain = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic last);
		stroke_point_t pt;
		pt.x = x;
		pt.y = y;
		pt.z = z;
		pt.last = last;
		pending_points.insert(pending_points.size(), pt);
	endtask

	// style 0: small random walk, 1: full-range noise, 2: repeated points
	task automatic add_stroke(int n, int style);
		logic signed [31:0] x, y, z;
		x = $urandom;
		y = $urandom;
		z = $urandom;
		for (int i = 0; i < n; i++) begin
			case (style)
				0: begin
					x = x + $signed($urandom_range(0, 'h3_FFFF)) - 'h2_0000;
					y = y + $signed($urandom_range(0, 'h3_FFFF)) - 'h2_0000;
					z = z + $signed($urandom_range(0, 'h3_FFFF)) - 'h2_0000;
				end
				1: begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) x = x + $urandom_range(0, 'hFFFF);
				end
			endcase
			add_point(x, y, z, i == n - 1);
		end
	endtask

	localparam logic signed [31:0] CMIN = 32'sh8000_0000;
	localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

	initial begin
		int sent, n, style, fulls;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short strokes pass through, repeated points give zero weights
		add_point(CMIN, CMAX, 0, 1'b1);
		add_point(CMAX, CMIN, -1, 1'b0);
		add_point(0, 1, CMAX, 1'b1);
		add_point(32'sh0001_0000, 0, 0, 1'b0);
		add_point(32'sh0001_0000, 0, 0, 1'b0);
		add_point(32'sh0001_0000, 0, 0, 1'b1);
		add_point(CMIN, CMIN, CMIN, 1'b0);
		add_point(CMAX, CMAX, CMAX, 1'b0);
		add_point(CMIN, CMAX, CMIN, 1'b0);
		add_point(CMAX, CMIN, 32'sh5555_5555, 1'b1);
		drain();

		// extremes of both registers, with saturating moves
		write_reg(pws_pkg::REG_PASS_COUNT, 16'd255);
		write_reg(pws_pkg::REG_STEP_GAIN, 16'hFFFF);
		add_point(CMIN, CMIN, CMIN, 1'b0);
		add_point(CMAX, CMAX, CMAX, 1'b0);
		add_point(CMIN, 0, CMAX, 1'b1);
		add_point(0, 0, 0, 1'b0);
		add_point(32'sh0010_0000, 32'sh0003_0000, -32'sh0002_0000, 1'b0);
		add_point(32'sh0020_0000, 0, 0, 1'b1);
		drain();
		write_reg(pws_pkg::REG_PASS_COUNT, 16'd0);
		write_reg(pws_pkg::REG_STEP_GAIN, 16'd0);
		add_point(CMAX, 0, 0, 1'b0);
		add_point(0, CMAX, 0, 1'b0);
		add_point(0, 0, CMAX, 1'b1);
		drain();
		write_reg(pws_pkg::REG_PASS_COUNT, 16'd1);
		add_point(CMAX, 0, 0, 1'b0);
		add_point(0, CMIN, 0, 1'b0);
		add_point(0, 0, CMAX, 1'b1);
		drain();

		sent = 0;
		fulls = 0;
		while (sent < 350) begin
			if (sent > 230) begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end else if (sent > 115) begin
				src_idle_pct = 78;
				snk_stall_pct = 11;
			end
			write_reg(pws_pkg::REG_PASS_COUNT,
				$urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 4)));
			write_reg(pws_pkg::REG_STEP_GAIN,
				$urandom_range(0, 4) == 0 ? 16'hFFFF : 16'($urandom));
			for (int s = 0; s < 5; s++) begin
				case ($urandom_range(0, 19))
					0: n = $urandom_range(1, 2);
					1: n = $urandom_range(40, 64);
					default: n = $urandom_range(3, 10);
				endcase
				style = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
				add_stroke(n, style);
				sent += n;
			end
			drain();
			// one full-buffer stroke in each third, dropping the last point or more
			if (fulls < 3 && sent > 60 + 115 * fulls) begin
				write_reg(pws_pkg::REG_PASS_COUNT, 16'd1);
				n = STROKE_CAP + $urandom_range(1, 3);
				add_stroke(n, 0);
				add_stroke(3, 0);
				sent += n + 3;
				fulls++;
				drain();
			end
		end
		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/pws_pkg.sv
src/pws_isqrt.sv
src/pws_div.sv
src/pws_dp.sv
src/pws_ctrl.sv
src/polyline_weighted_smoothing.sv
bench/polyline_weighted_smoothing_tb.sv
